// File: rtl/p2pr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2pr_pkg
// Shared widths, register codes and pipeline sideband types for the
// pixel-to-point reprojection block.
// ----------------------------------------------------------------------------
package p2pr_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 8;

   localparam int CFG_W     = 24;
   localparam int VAL_W     = 16;
   localparam int COLOR_W   = 8;
   localparam int OUT_W     = 40;
   localparam int CSR_IDX_W = 3;

   localparam int VAL_SH_W  = VAL_W + FRAC_BITS;
   localparam int POS_SH_W  = COORD_BITS + FRAC_BITS;
   // magnitude of a positive disparity denominator
   localparam int DEN_W     = ((VAL_SH_W > CFG_W) ? VAL_SH_W : CFG_W) + 1;
   localparam int DXM_W     = (POS_SH_W > CFG_W) ? POS_SH_W : CFG_W;
   localparam int DEPTH_W   = OUT_W;
   localparam int HALF_W    = DEPTH_W / 2;
   localparam int PROD_W    = DXM_W + DEPTH_W;
   localparam int FB_W      = 2 * CFG_W;
   localparam int DIV_NUM_W = (PROD_W > FB_W) ? PROD_W : FB_W;
   localparam int DIV_DEN_W = (DEN_W > CFG_W) ? DEN_W : CFG_W;

   localparam logic [DEPTH_W-1:0] MAG_CAP     = {1'b1, {(DEPTH_W-1){1'b0}}};
   localparam logic [CFG_W-1:0]   FOCAL_RESET = CFG_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH_MODE = 3'd0,
      CSR_FOCAL_X    = 3'd1,
      CSR_FOCAL_Y    = 3'd2,
      CSR_CENTER_X   = 3'd3,
      CSR_CENTER_Y   = 3'd4,
      CSR_BASELINE   = 3'd5,
      CSR_DISP_OFS   = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic                status;
      logic                mode;
      logic [VAL_SH_W-1:0] val_sh;
      logic                x_neg;
      logic [DXM_W-1:0]    x_mag;
      logic                y_neg;
      logic [DXM_W-1:0]    y_mag;
      logic [COLOR_W-1:0]  blue;
      logic [COLOR_W-1:0]  green;
      logic [COLOR_W-1:0]  red;
   } front_side_type;

   typedef struct packed {
      logic                status;
      logic                x_neg;
      logic [DXM_W-1:0]    x_mag;
      logic                y_neg;
      logic [DXM_W-1:0]    y_mag;
      logic [DEPTH_W-1:0]  depth;
      logic [COLOR_W-1:0]  blue;
      logic [COLOR_W-1:0]  green;
      logic [COLOR_W-1:0]  red;
   } mid_side_type;

   typedef struct packed {
      logic                status;
      logic                x_neg;
      logic                x_zero;
      logic                y_neg;
      logic                y_zero;
      logic [DEPTH_W-1:0]  depth;
      logic [COLOR_W-1:0]  blue;
      logic [COLOR_W-1:0]  green;
      logic [COLOR_W-1:0]  red;
   } back_side_type;

   typedef struct packed {
      logic               status;
      logic [OUT_W-1:0]   x;
      logic [OUT_W-1:0]   y;
      logic [OUT_W-1:0]   z;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } result_type;

endpackage

// File: rtl/p2pr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2pr_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module p2pr_div (
   input  logic                           clock,
   input  logic                           adv,
   input  logic [p2pr_pkg::DIV_NUM_W-1:0] num,
   input  logic [p2pr_pkg::DIV_DEN_W-1:0] den,
   output logic [p2pr_pkg::DIV_NUM_W-1:0] quo
);
   import p2pr_pkg::*;

   localparam int N  = DIV_NUM_W;
   localparam int RW = DIV_DEN_W + 1;

   logic [DIV_DEN_W-1:0] rem_ff [N];
   logic [N-1:0]         nq_ff  [N];
   logic [DIV_DEN_W-1:0] den_ff [N];

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_stage
         logic [DIV_DEN_W-1:0] r_src;
         logic [N-1:0]         q_src;
         logic [DIV_DEN_W-1:0] d_src;
         logic [RW-1:0]        part;
         logic [RW-1:0]        diff;
         logic [DIV_DEN_W-1:0] rem_in;
         logic [N-1:0]         nq_in;

         if (g == 0) begin : g_first
            assign r_src = '0;
            assign q_src = num;
            assign d_src = den;
         end else begin : g_next
            assign r_src = rem_ff[g-1];
            assign q_src = nq_ff[g-1];
            assign d_src = den_ff[g-1];
         end

         always_comb begin
            part = {r_src, q_src[N-1]};
            diff = part - {1'b0, d_src};
            if (part >= {1'b0, d_src}) begin
               rem_in = diff[DIV_DEN_W-1:0];
               nq_in  = {q_src[N-2:0], 1'b1};
            end else begin
               rem_in = part[DIV_DEN_W-1:0];
               nq_in  = {q_src[N-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[g] <= rem_in;
               nq_ff[g]  <= nq_in;
               den_ff[g] <= d_src;
            end
         end
      end
   endgenerate

   assign quo = nq_ff[N-1];

endmodule

// File: rtl/pixel_to_point_reprojection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_point_reprojection
// Reprojects one disparity or depth pixel to a colored 3-D point.
// ----------------------------------------------------------------------------
// Input beats (req_*) carry row, column, a 16-bit sample and three color
// bytes; a beat is taken when req_valid is high and req_stall is low. A
// sample of zero is taken and produces no result. Each other beat gives one
// result beat on rsp_* with status, point_x/y/z in signed Q.8 and the colors.
// The csr_* port writes the seven calibration registers; write them only
// while no pixel is in flight.
// Throughput is one pixel per clock while req_stall is low. The path runs
// through two entry stages, the depth divider (one
// quotient bit per stage), three stages of depth select and split
// multiply, the x/y dividers, and the output register.
// A stalled result waits in the output register; one more beat lands in a
// skid register, then req_stall rises and the whole pipeline holds until
// the receiver takes the output. Nothing is dropped or repeated.
// Reset (synchronous) empties the pipeline and restores the registers to
// depth_mode 0, focal lengths 256, everything else 0.
// ----------------------------------------------------------------------------
module pixel_to_point_reprojection (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [p2pr_pkg::COORD_BITS-1:0]        req_pixel_row,
   input  logic [p2pr_pkg::COORD_BITS-1:0]        req_pixel_col,
   input  logic [p2pr_pkg::VAL_W-1:0]             req_pixel_value,
   input  logic [p2pr_pkg::COLOR_W-1:0]           req_blue,
   input  logic [p2pr_pkg::COLOR_W-1:0]           req_green,
   input  logic [p2pr_pkg::COLOR_W-1:0]           req_red,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_status,
   output logic signed [p2pr_pkg::OUT_W-1:0]      rsp_point_x,
   output logic signed [p2pr_pkg::OUT_W-1:0]      rsp_point_y,
   output logic signed [p2pr_pkg::OUT_W-1:0]      rsp_point_z,
   output logic [p2pr_pkg::COLOR_W-1:0]           rsp_out_blue,
   output logic [p2pr_pkg::COLOR_W-1:0]           rsp_out_green,
   output logic [p2pr_pkg::COLOR_W-1:0]           rsp_out_red,
   input  logic                                   csr_write,
   input  logic [p2pr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [p2pr_pkg::CFG_W-1:0]             csr_wdata
);
   import p2pr_pkg::*;

   localparam int N = DIV_NUM_W;

   // calibration registers
   logic             depth_mode_ff;
   logic [CFG_W-1:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [CFG_W-1:0] baseline_ff, disp_ofs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_mode_ff <= 1'b0;
         focal_x_ff    <= FOCAL_RESET;
         focal_y_ff    <= FOCAL_RESET;
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         baseline_ff   <= '0;
         disp_ofs_ff   <= '0;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_DEPTH_MODE: depth_mode_ff <= csr_wdata[0];
            CSR_FOCAL_X:    focal_x_ff    <= csr_wdata;
            CSR_FOCAL_Y:    focal_y_ff    <= csr_wdata;
            CSR_CENTER_X:   center_x_ff   <= csr_wdata;
            CSR_CENTER_Y:   center_y_ff   <= csr_wdata;
            CSR_BASELINE:   baseline_ff   <= csr_wdata;
            CSR_DISP_OFS:   disp_ofs_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advance, held only while the skid register is occupied
   logic skid_full_ff;
   logic adv;
   assign adv       = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // ---------------- stage A: offsets, denominator, sign split
   logic [VAL_SH_W-1:0]    val_sh;
   logic [POS_SH_W-1:0]    col_sh, row_sh;
   logic signed [DEN_W:0]  den_s;
   logic signed [DXM_W:0]  dx_s, dy_s;
   logic [DXM_W:0]         dx_abs, dy_abs;
   front_side_type         a_side_in;

   always_comb begin
      val_sh = {req_pixel_value, {FRAC_BITS{1'b0}}};
      col_sh = {req_pixel_col, {FRAC_BITS{1'b0}}};
      row_sh = {req_pixel_row, {FRAC_BITS{1'b0}}};
      den_s  = $signed((DEN_W+1)'(val_sh)) + (DEN_W+1)'($signed(disp_ofs_ff));
      dx_s   = $signed((DXM_W+1)'(col_sh)) - $signed((DXM_W+1)'(center_x_ff));
      dy_s   = $signed((DXM_W+1)'(center_y_ff)) - $signed((DXM_W+1)'(row_sh));
      dx_abs = dx_s[DXM_W] ? (DXM_W+1)'(-dx_s) : dx_s;
      dy_abs = dy_s[DXM_W] ? (DXM_W+1)'(-dy_s) : dy_s;
      a_side_in.status = !depth_mode_ff && (den_s <= 0);
      a_side_in.mode   = depth_mode_ff;
      a_side_in.val_sh = val_sh;
      a_side_in.x_neg  = dx_s[DXM_W];
      a_side_in.x_mag  = dx_abs[DXM_W-1:0];
      a_side_in.y_neg  = dy_s[DXM_W];
      a_side_in.y_mag  = dy_abs[DXM_W-1:0];
      a_side_in.blue   = req_blue;
      a_side_in.green  = req_green;
      a_side_in.red    = req_red;
   end

   logic                 a_vld_ff;
   front_side_type       a_side_ff;
   logic [DIV_DEN_W-1:0] a_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid && (req_pixel_value != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_side_ff <= a_side_in;
         a_den_ff  <= DIV_DEN_W'(den_s[DEN_W-1:0]);
      end
   end

   // ---------------- stage B: focal_x * baseline
   logic                 b_vld_ff;
   front_side_type       b_side_ff;
   logic [DIV_DEN_W-1:0] b_den_ff;
   logic [FB_W-1:0]      b_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_side_ff <= a_side_ff;
         b_den_ff  <= a_den_ff;
         b_prod_ff <= FB_W'(focal_x_ff) * FB_W'(baseline_ff);
      end
   end

   // ---------------- depth divider with sideband line
   logic [N-1:0]         q_depth;
   logic [N-1:0]         fs_vld_ff;
   front_side_type       fs_ff [N];

   p2pr_div u_div_depth (
      .clock (clock),
      .adv   (adv),
      .num   (N'(b_prod_ff)),
      .den   (b_den_ff),
      .quo   (q_depth)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_vld_ff <= '0;
      end else if (adv) begin
         fs_vld_ff <= {fs_vld_ff[N-2:0], b_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fs_ff[0] <= b_side_ff;
         for (int i = 1; i < N; i++) begin
            fs_ff[i] <= fs_ff[i-1];
         end
      end
   end

   // ---------------- stage C: depth select and cap
   front_side_type fs_last;
   mid_side_type   c_side_in;
   logic           c_vld_ff;
   mid_side_type   c_side_ff;

   always_comb begin
      fs_last = fs_ff[N-1];
      c_side_in.status = fs_last.status;
      c_side_in.x_neg  = fs_last.x_neg;
      c_side_in.x_mag  = fs_last.x_mag;
      c_side_in.y_neg  = fs_last.y_neg;
      c_side_in.y_mag  = fs_last.y_mag;
      if (fs_last.mode) begin
         c_side_in.depth = DEPTH_W'(fs_last.val_sh);
      end else if (q_depth > N'(MAG_CAP)) begin
         c_side_in.depth = MAG_CAP;
      end else begin
         c_side_in.depth = q_depth[DEPTH_W-1:0];
      end
      c_side_in.blue  = fs_last.blue;
      c_side_in.green = fs_last.green;
      c_side_in.red   = fs_last.red;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= fs_vld_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_side_ff <= c_side_in;
      end
   end

   // ---------------- stage D: split products, depth cut in two halves
   localparam int LO_P_W = DXM_W + HALF_W;
   localparam int HI_P_W = DXM_W + DEPTH_W - HALF_W;

   logic                d_vld_ff;
   back_side_type       d_side_ff;
   logic [LO_P_W-1:0]   d_xl_ff, d_yl_ff;
   logic [HI_P_W-1:0]   d_xh_ff, d_yh_ff;
   back_side_type       d_side_in;

   always_comb begin
      d_side_in.status = c_side_ff.status;
      d_side_in.x_neg  = c_side_ff.x_neg;
      d_side_in.x_zero = (c_side_ff.x_mag == '0) || (c_side_ff.depth == '0);
      d_side_in.y_neg  = c_side_ff.y_neg;
      d_side_in.y_zero = (c_side_ff.y_mag == '0) || (c_side_ff.depth == '0);
      d_side_in.depth  = c_side_ff.depth;
      d_side_in.blue   = c_side_ff.blue;
      d_side_in.green  = c_side_ff.green;
      d_side_in.red    = c_side_ff.red;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_side_ff <= d_side_in;
         d_xl_ff <= LO_P_W'(c_side_ff.x_mag) * LO_P_W'(c_side_ff.depth[HALF_W-1:0]);
         d_yl_ff <= LO_P_W'(c_side_ff.y_mag) * LO_P_W'(c_side_ff.depth[HALF_W-1:0]);
         d_xh_ff <= HI_P_W'(c_side_ff.x_mag) * HI_P_W'(c_side_ff.depth[DEPTH_W-1:HALF_W]);
         d_yh_ff <= HI_P_W'(c_side_ff.y_mag) * HI_P_W'(c_side_ff.depth[DEPTH_W-1:HALF_W]);
      end
   end

   // ---------------- stage E: join partial products
   logic          e_vld_ff;
   back_side_type e_side_ff;
   logic [N-1:0]  e_nx_ff, e_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_side_ff <= d_side_ff;
         e_nx_ff   <= (N'(d_xh_ff) << HALF_W) + N'(d_xl_ff);
         e_ny_ff   <= (N'(d_yh_ff) << HALF_W) + N'(d_yl_ff);
      end
   end

   // ---------------- x and y dividers with sideband line
   logic [N-1:0]  q_x, q_y;
   logic [N-1:0]  bs_vld_ff;
   back_side_type bs_ff [N];

   p2pr_div u_div_x (
      .clock (clock),
      .adv   (adv),
      .num   (e_nx_ff),
      .den   (DIV_DEN_W'(focal_x_ff)),
      .quo   (q_x)
   );

   p2pr_div u_div_y (
      .clock (clock),
      .adv   (adv),
      .num   (e_ny_ff),
      .den   (DIV_DEN_W'(focal_y_ff)),
      .quo   (q_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_vld_ff <= '0;
      end else if (adv) begin
         bs_vld_ff <= {bs_vld_ff[N-2:0], e_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bs_ff[0] <= e_side_ff;
         for (int i = 1; i < N; i++) begin
            bs_ff[i] <= bs_ff[i-1];
         end
      end
   end

   // ---------------- output formatting, output register and skid
   function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [N-1:0] mag);
      logic [N-1:0] cap;
      cap = N'(MAG_CAP);
      if (neg) begin
         if (mag > cap) begin
            return MAG_CAP;
         end
         return OUT_W'(0) - mag[OUT_W-1:0];
      end
      if (mag >= cap) begin
         return MAG_CAP - OUT_W'(1);
      end
      return mag[OUT_W-1:0];
   endfunction

   back_side_type bs_last;
   result_type    res_in;

   always_comb begin
      bs_last      = bs_ff[N-1];
      res_in.status = bs_last.status;
      res_in.blue   = bs_last.blue;
      res_in.green  = bs_last.green;
      res_in.red    = bs_last.red;
      if (bs_last.status) begin
         res_in.x = '0;
         res_in.y = '0;
         res_in.z = '0;
      end else begin
         // zero numerator gives zero even with a zero focal length
         res_in.x = bs_last.x_zero ? '0 : sat_out(bs_last.x_neg, q_x);
         res_in.y = bs_last.y_zero ? '0 : sat_out(bs_last.y_neg, q_y);
         res_in.z = OUT_W'(0) - bs_last.depth;
      end
   end

   logic       out_vld_ff;
   result_type out_ff, skid_ff;
   logic       out_fire, new_beat;

   assign out_fire = out_vld_ff && !rsp_stall;
   assign new_beat = adv && bs_vld_ff[N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff   <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         if (new_beat) begin
            if (!out_vld_ff || out_fire) begin
               out_vld_ff <= 1'b1;
            end else begin
               skid_full_ff <= 1'b1;
            end
         end else if (out_fire) begin
            if (skid_full_ff) begin
               skid_full_ff <= 1'b0;
            end else begin
               out_vld_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (new_beat) begin
         if (!out_vld_ff || out_fire) begin
            out_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end else if (out_fire && skid_full_ff) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_status    = out_ff.status;
   assign rsp_point_x   = out_ff.x;
   assign rsp_point_y   = out_ff.y;
   assign rsp_point_z   = out_ff.z;
   assign rsp_out_blue  = out_ff.blue;
   assign rsp_out_green = out_ff.green;
   assign rsp_out_red   = out_ff.red;

endmodule

// File: rtl/p2pr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2pr_checker
// Port-level assertions for the reprojection block, bound to its top level.
// ----------------------------------------------------------------------------
module p2pr_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_stall,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic                                   rsp_status,
   input  logic signed [p2pr_pkg::OUT_W-1:0]      rsp_point_x,
   input  logic signed [p2pr_pkg::OUT_W-1:0]      rsp_point_y,
   input  logic signed [p2pr_pkg::OUT_W-1:0]      rsp_point_z
);
   import p2pr_pkg::*;

   // the pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // back-pressure upstream only after a result was held downstream
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall rose without a stalled result");

   // a bad denominator carries no coordinates
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |->
         rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0)
      else $error("status beat with nonzero coordinates");

   // a held result beat keeps its status and its x and z coordinates
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x)
         && $stable(rsp_point_z) && $stable(rsp_status))
      else $error("stalled result beat changed");

endmodule

bind pixel_to_point_reprojection p2pr_checker u_p2pr_checker (.*);
